>>> rtl/osel_pkg.sv
package osel_pkg;

  localparam int SRC_W  = 5;
  localparam int MASK_W = 32;

  localparam logic [1:0] ACT_SET      = 2'd0;
  localparam logic [1:0] ACT_DISPATCH = 2'd1;
  localparam logic [1:0] ACT_QUERY    = 2'd2;

  typedef struct packed {
    logic [1:0]       action;
    logic [SRC_W-1:0] source;
    logic             enable;
  } req_t;

  typedef struct packed {
    logic              entry_valid;
    logic [SRC_W-1:0]  dispatched_source;
    logic              is_enabled;
    logic [MASK_W-1:0] enable_mask;
    logic              last;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_APPEND,
    ST_SCAN,
    ST_SCAN_END,
    ST_DSP_RD,
    ST_DSP_LD,
    ST_REPLY
  } state_t;

  typedef struct packed {
    logic accept;
    logic append;
    logic scan;
    logic scan_end;
    logic dsp_read;
    logic dsp_load;
    logic reply_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       set_en;
    logic       in_range;
    logic       src_bit;
    logic       empty;
    logic       scan_done;
    logic       dsp_last;
    logic       out_free;
  } sts_t;

endpackage

>>> rtl/ordered_source_enable_list_core.sv
// Ordered list of enabled interrupt sources plus a one-bit-per-source enable
// mask. One transaction is taken at a time; the block stalls its request side
// until every result of the current one has been loaded into the result
// register. Set and query give one result, held back by any output stall.
// Enabling appends the source at the tail; disabling scans the list through
// the list memory's read port, one entry read per cycle, shifting later
// entries down through its write port as it goes. Dispatch reads the list
// memory once per entry and loads that entry's result, waiting while the
// result register is full, before it reads the next; an empty list gives a
// single result with entry_valid low. Sources at or above NUM_SOURCES are
// never enabled.
module ordered_source_enable_list_core
  import osel_pkg::*;
#(
  parameter int NUM_SOURCES = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  cmd_t cmd;
  sts_t sts;

  osel_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  osel_dp #(
    .NUM_SOURCES (NUM_SOURCES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

>>> rtl/osel_ctrl.sv
module osel_ctrl
  import osel_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   req_valid,
  output logic   req_stall,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts.action == ACT_SET && sts.in_range && sts.set_en && !sts.src_bit) begin
          state_next = ST_APPEND;
        end else if (sts.action == ACT_SET && sts.in_range && !sts.set_en &&
                     sts.src_bit) begin
          state_next = ST_SCAN;
        end else if (sts.action == ACT_DISPATCH && !sts.empty) begin
          state_next = ST_DSP_RD;
        end else begin
          state_next = ST_REPLY;
        end
      end
      ST_APPEND:   state_next = ST_REPLY;
      ST_SCAN: begin
        if (sts.scan_done) state_next = ST_SCAN_END;
      end
      ST_SCAN_END: state_next = ST_REPLY;
      ST_DSP_RD:   state_next = ST_DSP_LD;
      ST_DSP_LD: begin
        if (sts.out_free) state_next = sts.dsp_last ? ST_IDLE : ST_DSP_RD;
      end
      ST_REPLY: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        req_stall  = 1'b0;
        cmd.accept = req_valid;
      end
      ST_APPEND:   cmd.append     = 1'b1;
      ST_SCAN:     cmd.scan       = 1'b1;
      ST_SCAN_END: cmd.scan_end   = 1'b1;
      ST_DSP_RD:   cmd.dsp_read   = 1'b1;
      ST_DSP_LD:   cmd.dsp_load   = sts.out_free;
      ST_REPLY:    cmd.reply_load = sts.out_free;
      default:     cmd            = '0;
    endcase
  end

endmodule

>>> rtl/osel_dp.sv
module osel_dp
  import osel_pkg::*;
#(
  parameter int NUM_SOURCES = 32
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp,
  input  cmd_t cmd,
  output sts_t sts
);

  localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int CNT_W = $clog2(NUM_SOURCES + 1);

  logic [SRC_W-1:0]       mem [NUM_SOURCES];
  logic [SRC_W-1:0]       rd_data;
  logic [IDX_W-1:0]       rd_idx;
  logic                   sc_vld;
  logic                   found;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       ptr;
  logic [NUM_SOURCES-1:0] mask;
  req_t                   item;

  logic [MASK_W-1:0]      mask32;
  logic                   src_bit;
  logic                   in_range;
  logic                   rd_en;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [SRC_W-1:0]       wr_data;
  logic                   out_free;

  assign mask32   = MASK_W'(mask);
  assign in_range = {1'b0, item.source} < (SRC_W + 1)'(NUM_SOURCES);
  assign src_bit  = in_range & mask32[item.source];
  assign out_free = !rsp_valid || !rsp_stall;
  assign rd_en    = cmd.dsp_read || (cmd.scan && (ptr < count));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[IDX_W-1:0];
    wr_data = item.source;
    if (cmd.append) begin
      wr_en = 1'b1;
    end else if (sc_vld && found) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx - IDX_W'(1);
      wr_data = rd_data;
    end
  end

  // list storage
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      rd_data <= mem[ptr[IDX_W-1:0]];
      rd_idx  <= ptr[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) item <= req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      mask   <= '0;
      ptr    <= '0;
      found  <= 1'b0;
      sc_vld <= 1'b0;
    end else begin
      sc_vld <= cmd.scan && rd_en;
      if (cmd.accept) begin
        ptr   <= '0;
        found <= 1'b0;
      end else if (rd_en) begin
        ptr <= ptr + CNT_W'(1);
      end
      if (sc_vld && rd_data == item.source) found <= 1'b1;
      if (cmd.append) begin
        count <= count + CNT_W'(1);
        mask  <= mask | NUM_SOURCES'(MASK_W'(1) << item.source);
      end else if (cmd.scan_end) begin
        count <= count - CNT_W'(1);
        mask  <= mask & ~NUM_SOURCES'(MASK_W'(1) << item.source);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.dsp_load || cmd.reply_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dsp_load) begin
      rsp.entry_valid       <= 1'b1;
      rsp.dispatched_source <= rd_data;
      rsp.is_enabled        <= mask32[rd_data];
      rsp.enable_mask       <= mask32;
      rsp.last              <= sts.dsp_last;
    end else if (cmd.reply_load) begin
      rsp.entry_valid       <= 1'b0;
      rsp.dispatched_source <= '0;
      rsp.is_enabled        <= (item.action == ACT_DISPATCH) ? 1'b0 : src_bit;
      rsp.enable_mask       <= mask32;
      rsp.last              <= 1'b1;
    end
  end

  always_comb begin
    sts.action    = item.action;
    sts.set_en    = item.enable;
    sts.in_range  = in_range;
    sts.src_bit   = src_bit;
    sts.empty     = (count == '0);
    sts.scan_done = (ptr == count) && !sc_vld;
    sts.dsp_last  = (CNT_W'(rd_idx) + CNT_W'(1)) == count;
    sts.out_free  = out_free;
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(NUM_SOURCES))
    else $error("list count beyond depth");

  a_mask_count: assert property (@(posedge clk) disable iff (rst)
    $countones(mask) == int'(count))
    else $error("mask and list count disagree");

  a_scan_found: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_end |-> found)
    else $error("removed source not found in list");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> (count < CNT_W'(NUM_SOURCES)))
    else $error("append on full list");
`endif

endmodule
